/* rtl/mleb_pkg.sv */
`default_nettype none

package mleb_pkg;

  localparam int unsigned MAX_LEN_DEF = 255;

  localparam logic [7:0] MASK_RESET = 8'd165;

  // request codes
  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // key codes
  localparam logic [7:0] KEY_LF       = 8'h0A;
  localparam logic [7:0] KEY_CR       = 8'h0D;
  localparam logic [7:0] KEY_ENTER    = 8'h03;
  localparam logic [7:0] KEY_BS       = 8'h08;
  localparam logic [7:0] KEY_TAB      = 8'h09;
  localparam logic [7:0] KEY_ARROW_LO = 8'h1C;
  localparam logic [7:0] KEY_ARROW_HI = 8'h1F;

  // action codes
  localparam logic [2:0] ACT_EDITED = 3'd0;
  localparam logic [2:0] ACT_SUBMIT = 3'd1;
  localparam logic [2:0] ACT_PASS   = 3'd2;
  localparam logic [2:0] ACT_FULL   = 3'd3;
  localparam logic [2:0] ACT_BADSEL = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_code;
    logic [7:0] sel_start;
    logic [7:0] sel_end;
    logic [7:0] read_pos;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] echo_char;
    logic [7:0] text_length;
    logic [7:0] read_char;
  } rsp_t;

  typedef logic [7:0] cfg_t;

  // broadcast to every cell
  typedef struct packed {
    logic       shl;  // cells at or above pos take the right neighbor
    logic       shr;  // cells above pos take the left neighbor, pos takes chr
    logic [7:0] pos;
    logic [7:0] chr;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/mleb_chan_if.sv */
`default_nettype none

interface mleb_chan_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mleb_cell.sv */
`default_nettype none

module mleb_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                 clk,
  input  mleb_pkg::cell_ctl_t ctl,
  input  wire  [7:0]          left_data,
  input  wire  [7:0]          right_data,
  input  wire  [7:0]          right_rd,
  output logic [7:0]          data,
  output logic [7:0]          rd_link
);

  localparam logic [7:0] MY_IDX = 8'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.shl && (MY_IDX >= ctl.pos)) begin
      data <= right_data;
    end else if (ctl.shr) begin
      if (MY_IDX > ctl.pos) begin
        data <= left_data;
      end else if (MY_IDX == ctl.pos) begin
        data <= ctl.chr;
      end
    end
  end

  // read word walks toward cell zero one step a cycle
  always_ff @(posedge clk) begin
    rd_link <= (MY_IDX == ctl.pos) ? data : right_rd;
  end

endmodule

`default_nettype wire

/* rtl/masked_line_edit_buffer_top.sv */
// channel  role    payload
// req      sink    mleb_pkg::req_t  (req_type, key_code, sel_start, sel_end, read_pos)
// rsp      source  mleb_pkg::rsp_t  (action, echo_char, text_length, read_char)
// cfg      sink    mleb_pkg::cfg_t  (mask_char), always ready
//
// one request at a time; req is ready only while no request is in work
// edits move the byte row one position per cycle; a keystroke with a selection
// cuts it in the shift step and then inserts unless backspace, a single insert
// or backspace takes one insert or shift step, keys that change nothing go to
// the finish step; a read within the line waits while the word travels down the
// cell row to cell zero; reads past the end and clears go to the finish step
// rst clears length and the control and sets the mask char to its reset value; stored bytes are not cleared
// a stalled rsp word holds; the next result waits in the finish step
`default_nettype none

module masked_line_edit_buffer_top #(
  parameter int unsigned MAX_LEN = mleb_pkg::MAX_LEN_DEF
) (
  input wire          clk,
  input wire          rst,
  mleb_chan_if.sink   req,
  mleb_chan_if.source rsp,
  mleb_chan_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [7:0] FULL_LEN = 8'(MAX_LEN);

  logic [2:0]     state;
  logic [7:0]     count;
  logic [7:0]     mask_char;
  logic [7:0]     op_pos;
  logic [7:0]     op_char;
  logic [7:0]     shl_left;
  logic [7:0]     rd_cnt;
  logic           do_ins;
  logic [2:0]     res_action;
  logic [7:0]     res_echo;
  logic [7:0]     res_rd;
  logic           out_valid;
  mleb_pkg::rsp_t out_data;

  mleb_pkg::req_t    rq;
  mleb_pkg::cell_ctl_t ctl;
  logic              is_submit;
  logic              is_pass;
  logic              bad_sel;
  logic              had_sel;
  logic [7:0]        gap;
  logic              out_free;

  logic [2:0]        state_next;
  logic [2:0]        res_action_next;
  logic [7:0]        res_echo_next;
  logic [7:0]        op_pos_next;
  logic [7:0]        shl_left_next;
  logic              do_ins_next;

  logic [7:0] data_w [MAX_LEN];
  logic [7:0] rd_w   [MAX_LEN];

  assign rq        = req.data;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    is_submit = rq.key_code inside {mleb_pkg::KEY_LF, mleb_pkg::KEY_CR,
                                    mleb_pkg::KEY_ENTER};
    is_pass   = (rq.key_code == mleb_pkg::KEY_TAB) ||
                (rq.key_code inside {[mleb_pkg::KEY_ARROW_LO:mleb_pkg::KEY_ARROW_HI]});
    bad_sel   = (rq.sel_start > count) || (rq.sel_end > count) ||
                (rq.sel_start > rq.sel_end);
    had_sel   = (rq.sel_start != rq.sel_end);
    gap       = rq.sel_end - rq.sel_start;
  end

  // decode of an accepted request
  always_comb begin
    state_next      = ST_FIN;
    res_action_next = mleb_pkg::ACT_DONE;
    res_echo_next   = 8'h00;
    op_pos_next     = rq.sel_start;
    shl_left_next   = gap;
    do_ins_next     = 1'b0;
    case (rq.req_type)
      mleb_pkg::REQ_KEY: begin
        res_echo_next = rq.key_code;
        if (is_submit) begin
          res_action_next = mleb_pkg::ACT_SUBMIT;
        end else if (is_pass) begin
          res_action_next = mleb_pkg::ACT_PASS;
        end else if (bad_sel) begin
          res_action_next = mleb_pkg::ACT_BADSEL;
        end else begin
          res_action_next = mleb_pkg::ACT_EDITED;
          if (had_sel) begin
            // cut the selection first, then insert unless backspace
            state_next = ST_SHIFT;
            if (rq.key_code != mleb_pkg::KEY_BS) begin
              do_ins_next   = 1'b1;
              res_echo_next = mask_char;
            end
          end else if (rq.key_code == mleb_pkg::KEY_BS) begin
            if (rq.sel_start != 8'd0) begin
              op_pos_next   = rq.sel_start - 8'd1;
              shl_left_next = 8'd1;
              state_next    = ST_SHIFT;
            end
          end else if (count >= FULL_LEN) begin
            res_action_next = mleb_pkg::ACT_FULL;
          end else begin
            res_echo_next = mask_char;
            state_next    = ST_INS;
          end
        end
      end
      mleb_pkg::REQ_READ: begin
        if (rq.read_pos < count) begin
          op_pos_next = rq.read_pos;
          state_next  = ST_READ;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.shl = (state == ST_SHIFT);
    ctl.shr = (state == ST_INS);
    ctl.pos = op_pos;
    ctl.chr = op_char;
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [7:0] left_d;
    logic [7:0] right_d;
    logic [7:0] right_r;
    if (i == 0) begin : g_first
      assign left_d = 8'h00;
    end else begin : g_mid_l
      assign left_d = data_w[i-1];
    end
    if (i == MAX_LEN - 1) begin : g_last
      assign right_d = 8'h00;
      assign right_r = 8'h00;
    end else begin : g_mid_r
      assign right_d = data_w[i+1];
      assign right_r = rd_w[i+1];
    end
    mleb_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .right_rd   (right_r),
      .data       (data_w[i]),
      .rd_link    (rd_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= 8'd0;
      mask_char <= mleb_pkg::MASK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mask_char <= cfg.data;
      end
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state      <= state_next;
            res_action <= res_action_next;
            res_echo   <= res_echo_next;
            res_rd     <= 8'h00;
            op_pos     <= op_pos_next;
            op_char    <= rq.key_code;
            shl_left   <= shl_left_next;
            do_ins     <= do_ins_next;
            rd_cnt     <= rq.read_pos + 8'd1;
            if (rq.req_type == mleb_pkg::REQ_CLEAR) begin
              count <= 8'd0;
            end
          end
        end
        ST_SHIFT: begin
          count    <= count - 8'd1;
          shl_left <= shl_left - 8'd1;
          if (shl_left == 8'd1) begin
            state <= do_ins ? ST_INS : ST_FIN;
          end
        end
        ST_INS: begin
          count <= count + 8'd1;
          state <= ST_FIN;
        end
        ST_READ: begin
          if (rd_cnt == 8'd0) begin
            res_rd <= rd_w[0];
            state  <= ST_FIN;
          end else begin
            rd_cnt <= rd_cnt - 8'd1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_data.action      <= res_action;
            out_data.echo_char   <= res_echo;
            out_data.text_length <= count;
            out_data.read_char   <= res_rd;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mleb_checker.sv */
`default_nettype none

module mleb_checker #(
  parameter int unsigned MAX_LEN = mleb_pkg::MAX_LEN_DEF
) (
  input wire       clk,
  input wire       rst,
  input wire       rsp_valid,
  input wire       rsp_ready,
  input wire [2:0] action,
  input wire [7:0] echo_char,
  input wire [7:0] text_length,
  input wire [7:0] read_char
);

  localparam logic [7:0] FULL_LEN = 8'(MAX_LEN);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  a_rd_only_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action != mleb_pkg::ACT_DONE) |-> (read_char == 8'h00))
    else $error("read byte on a keystroke result");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (action == mleb_pkg::ACT_FULL) |->
      (text_length == FULL_LEN) && (echo_char != 8'h00 || echo_char == 8'h00))
    else $error("full drop reported below full length");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (text_length <= FULL_LEN))
    else $error("length beyond buffer size");

endmodule

bind masked_line_edit_buffer_top mleb_checker #(.MAX_LEN(MAX_LEN)) u_mleb_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .action      (rsp.data.action),
  .echo_char   (rsp.data.echo_char),
  .text_length (rsp.data.text_length),
  .read_char   (rsp.data.read_char)
);

`default_nettype wire

/* test/tb_masked_line_edit_buffer_top.sv */
`timescale 1ns / 1ps

module tb_masked_line_edit_buffer_top;
  import mleb_pkg::*;

  localparam int unsigned LINE_MAX = MAX_LEN_DEF;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned HOLD_AT_WORD = 150;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // hidden line as the block should hold it
  typedef struct packed {
    logic [7:0]               mask;
    logic [7:0]               len;
    logic [7:0]               peak;   // highest length reached, bytes below it were written
    logic [LINE_MAX-1:0][7:0] chars;
  } line_image_t;

  logic clk;
  logic rst;

  mleb_chan_if #(.T(req_t)) req_ch ();
  mleb_chan_if #(.T(rsp_t)) rsp_ch ();
  mleb_chan_if #(.T(cfg_t)) cfg_ch ();

  masked_line_edit_buffer_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  line_image_t plan_line;   // advanced as requests are queued
  line_image_t live_line;   // advanced as requests are accepted
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  rsp_t        due_rsp;

  int unsigned words_queued, words_accepted, words_checked, mismatches;
  int unsigned long_holds;
  int unsigned send_gap, send_calm, recv_hold, recv_calm;
  int unsigned action_tally[8];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void cut_span(inout line_image_t m, input int unsigned lo,
                                   input int unsigned hi);
    int unsigned i;
    for (i = lo; i + (hi - lo) < m.len; i++) m.chars[i] = m.chars[i + hi - lo];
    m.len = m.len - 8'(hi - lo);
  endfunction

  function automatic rsp_t apply_request(inout line_image_t m, input req_t r);
    rsp_t o;
    logic had_sel;
    int unsigned i;
    o.action    = ACT_DONE;
    o.echo_char = 8'd0;
    o.read_char = 8'd0;
    case (r.req_type)
      REQ_KEY: begin
        o.echo_char = r.key_code;
        if (r.key_code == KEY_LF || r.key_code == KEY_CR || r.key_code == KEY_ENTER) begin
          o.action = ACT_SUBMIT;
        end else if (r.key_code == KEY_TAB ||
                     (r.key_code >= KEY_ARROW_LO && r.key_code <= KEY_ARROW_HI)) begin
          o.action = ACT_PASS;
        end else if (r.sel_start > m.len || r.sel_end > m.len ||
                     r.sel_start > r.sel_end) begin
          o.action = ACT_BADSEL;
        end else begin
          had_sel  = (r.sel_start != r.sel_end);
          o.action = ACT_EDITED;
          if (had_sel) cut_span(m, r.sel_start, r.sel_end);
          if (r.key_code == KEY_BS) begin
            if (!had_sel && r.sel_start != 8'd0) cut_span(m, r.sel_start - 1, r.sel_start);
          end else if (m.len >= 8'(LINE_MAX)) begin
            o.action = ACT_FULL;
          end else begin
            for (i = m.len; i > r.sel_start; i--) m.chars[i] = m.chars[i - 1];
            m.chars[r.sel_start] = r.key_code;
            m.len = m.len + 8'd1;
            o.echo_char = m.mask;
          end
        end
      end
      REQ_READ: begin
        if (r.read_pos < m.len) o.read_char = m.chars[r.read_pos];
      end
      REQ_CLEAR: m.len = 8'd0;
      default: ;
    endcase
    if (m.len > m.peak) m.peak = m.len;
    o.text_length = m.len;
    return o;
  endfunction

  function automatic req_t mk(logic [1:0] t, logic [7:0] k, logic [7:0] s, logic [7:0] e,
                              logic [7:0] p);
    req_t r;
    r.req_type  = t;
    r.key_code  = k;
    r.sel_start = s;
    r.sel_end   = e;
    r.read_pos  = p;
    return r;
  endfunction

  // any key that gets inserted: not submit, pass-through or backspace
  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    do begin
      k = 8'($urandom_range(0, 255));
    end while (k == KEY_LF || k == KEY_CR || k == KEY_ENTER || k == KEY_TAB ||
               k == KEY_BS || (k >= KEY_ARROW_LO && k <= KEY_ARROW_HI));
    return k;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic req_t random_request(input line_image_t m);
    req_t r;
    int unsigned pick, a, b;
    r = mk(REQ_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 254)));
    a = $urandom_range(0, m.len);
    b = a;
    if ($urandom_range(0, 3) == 0) b = $urandom_range(a, m.len);
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick >= 75 && pick < 90 && m.peak == 8'd0)) begin
      r.key_code  = plain_key();
      r.sel_start = 8'(a);
      r.sel_end   = 8'(b);
    end else if (pick < 60) begin
      r.key_code  = KEY_BS;
      r.sel_start = 8'(a);
      r.sel_end   = 8'(b);
    end else if (pick < 67) begin
      case ($urandom_range(0, 4))
        0: r.key_code = KEY_LF;
        1: r.key_code = KEY_CR;
        2: r.key_code = KEY_ENTER;
        3: r.key_code = KEY_TAB;
        default: r.key_code = KEY_ARROW_LO + 8'($urandom_range(0, 3));
      endcase
    end else if (pick < 75) begin
      r.key_code = ($urandom_range(0, 3) == 0) ? KEY_BS : plain_key();
      if (m.len == 8'(LINE_MAX) || $urandom_range(0, 2) == 0) begin
        // reversed selection
        r.sel_start = 8'($urandom_range(1, 255));
        r.sel_end   = 8'($urandom_range(0, r.sel_start - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        r.sel_start = 8'($urandom_range(m.len + 1, 255));
      end else begin
        r.sel_start = 8'(a);
        r.sel_end   = 8'($urandom_range(m.len + 1, 255));
      end
    end else if (pick < 90) begin
      r.req_type = REQ_READ;
      r.read_pos = 8'($urandom_range(0, m.peak - 1));
    end else if (pick < 93) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 95) begin
      r.req_type = REQ_UNUSED;
    end
    // rest: keystroke with every field random
    return r;
  endfunction

  task automatic post(input req_t r);
    rsp_t unused;
    unused = apply_request(plan_line, r);
    pending_reqs.push_back(r);
    words_queued++;
  endtask

  task automatic queue_mix(input int unsigned n);
    repeat (n) post(random_request(plan_line));
  endtask

  // type until the line is full, then push against the limit
  task automatic queue_fill();
    int unsigned c;
    while (plan_line.len < 8'(LINE_MAX)) begin
      c = $urandom_range(0, plan_line.len);
      if (plan_line.len > 8'd0 && $urandom_range(0, 15) == 0)
        post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'($urandom_range(0, plan_line.len - 1))));
      else
        post(mk(REQ_KEY, plain_key(), 8'(c), 8'(c), 8'd0));
    end
    repeat (5) begin
      c = $urandom_range(0, LINE_MAX);
      post(mk(REQ_KEY, plain_key(), 8'(c), 8'(c), 8'd0));
    end
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'(LINE_MAX - 1)));
    post(mk(REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'd200));
    post(mk(REQ_KEY, plain_key(), 8'd0, 8'(LINE_MAX), 8'd0));
    post(mk(REQ_KEY, plain_key(), 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, KEY_BS, 8'(LINE_MAX), 8'(LINE_MAX), 8'd0));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (words_accepted != words_queued || words_checked < words_accepted);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic [7:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid   <= 1'b0;
    plan_line.mask = v;
    live_line.mask = v;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // request side
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(apply_request(live_line, req_ch.data));
        words_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_ch.data  <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(20, 60);
          end else begin
            send_gap = idle_length();
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_hold = 0;
      recv_calm = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got %p", $time, rsp_ch.data);
        end else begin
          due_rsp = expected_rsps.pop_front();
          check_field("action", due_rsp.action, rsp_ch.data.action);
          check_field("echo_char", due_rsp.echo_char, rsp_ch.data.echo_char);
          check_field("text_length", due_rsp.text_length, rsp_ch.data.text_length);
          check_field("read_char", due_rsp.read_char, rsp_ch.data.read_char);
          action_tally[due_rsp.action]++;
        end
        words_checked++;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (long_holds == 0 && words_checked >= HOLD_AT_WORD) begin
        // long back-pressure so the request side backs up
        long_holds++;
        recv_hold = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 24) == 0) begin
        recv_calm = $urandom_range(20, 80);
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        recv_hold = idle_length();
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    plan_line      = '0;
    plan_line.mask = MASK_RESET;
    live_line      = plan_line;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: build a short line, then hit each key class and edge case
    post(mk(REQ_KEY, 8'h61, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, 8'hFF, 8'd1, 8'd1, 8'd0));
    post(mk(REQ_KEY, 8'h00, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, 8'h80, 8'd3, 8'd3, 8'd0));
    post(mk(REQ_KEY, 8'h7F, 8'd2, 8'd2, 8'd0));
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd4));
    post(mk(REQ_KEY, KEY_LF, 8'hFF, 8'hFF, 8'd0));
    post(mk(REQ_KEY, KEY_CR, 8'd9, 8'd2, 8'd0));
    post(mk(REQ_KEY, KEY_ENTER, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, KEY_TAB, 8'd200, 8'd100, 8'd0));
    post(mk(REQ_KEY, KEY_ARROW_LO, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, KEY_ARROW_HI, 8'hFF, 8'd0, 8'd0));
    post(mk(REQ_KEY, 8'h62, 8'd6, 8'd6, 8'd0));
    post(mk(REQ_KEY, 8'h62, 8'd3, 8'd1, 8'd0));
    post(mk(REQ_KEY, KEY_BS, 8'd0, 8'd9, 8'd0));
    post(mk(REQ_KEY, KEY_BS, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_KEY, KEY_BS, 8'd1, 8'd3, 8'd0));
    post(mk(REQ_KEY, KEY_BS, 8'd3, 8'd3, 8'd0));
    post(mk(REQ_KEY, 8'h63, 8'd0, 8'd2, 8'd0));
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0));
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd3));
    post(mk(REQ_CLEAR, 8'h55, 8'd7, 8'd7, 8'd1));
    post(mk(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
    post(mk(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0));
    wait_idle();

    write_mask(8'h00);
    queue_mix(220);
    wait_idle();

    write_mask(8'hFF);
    queue_fill();
    queue_mix(60);
    wait_idle();

    write_mask(8'($urandom_range(1, 254)));
    queue_mix(200);
    wait_idle();
    repeat (300) @(posedge clk);

    $display("covered %0d requests over four mask settings, line up to %0d bytes",
             words_checked, plan_line.peak);
    $display("edits %0d, full drops %0d, bad selections %0d, submit/pass %0d, read/clear %0d",
             action_tally[ACT_EDITED], action_tally[ACT_FULL], action_tally[ACT_BADSEL],
             action_tally[ACT_SUBMIT] + action_tally[ACT_PASS], action_tally[ACT_DONE]);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("tb_masked_line_edit_buffer_top OK");
    end else begin
      $display("tb_masked_line_edit_buffer_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d of %0d words accepted, %0d results checked", $time,
             words_accepted, words_queued, words_checked);
    $display("tb_masked_line_edit_buffer_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/mleb_pkg.sv
rtl/mleb_chan_if.sv
rtl/mleb_cell.sv
rtl/masked_line_edit_buffer_top.sv
rtl/mleb_checker.sv
test/tb_masked_line_edit_buffer_top.sv
